/* rtl/core/hpte_pkg.sv */
// ----------------------------------------------------------------------------
// hpte_pkg
// Types, codes and helpers shared by the hashed page table engine.
// ----------------------------------------------------------------------------
package hpte_pkg;

  localparam int GROUP_COUNT_DEF = 1024;
  localparam int WAYS_DEF        = 8;

  localparam int HASH_W      = 19;
  localparam int BASE_GRP_W  = 10;
  localparam int SIZE_MASK_W = 9;

  typedef enum logic [1:0] {
    CMD_MAP       = 2'd0,
    CMD_TRANSLATE = 2'd1,
    CMD_SET_PROT  = 2'd2,
    CMD_UNMAP     = 2'd3
  } hpte_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } hpte_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL_PRI,
    ST_EVAL_SEC,
    ST_WRITE_BACK,
    ST_RESPOND
  } hpte_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] prot_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys_result;
  } rsp_t;

  // One stored translation: tag fields, then the page word.
  typedef struct packed {
    logic        valid;
    logic [3:0]  seg;
    logic        sec;
    logic [5:0]  pidx;
    logic [19:0] rpn;
    logic [11:0] prot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load_item;
    logic read_sec;
    logic eval;
    logic eval_sec;
    logic wr_row;
    logic clear_wr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic found;
    logic needs_write;
    logic clear_last;
    logic out_busy;
  } ctrl_sts_t;

  function automatic logic [HASH_W-1:0] hpte_hash(input logic [31:0] va);
    return {3'b000, va[27:12]} ^ {15'd0, va[31:28]};
  endfunction

  function automatic logic [HASH_W-1:0] hpte_masked(input logic [HASH_W-1:0] h,
                                                    input logic [SIZE_MASK_W-1:0] sm);
    return h & {sm, {BASE_GRP_W{1'b1}}};
  endfunction

endpackage

/* rtl/core/hpte_ram.sv */
// ----------------------------------------------------------------------------
// hpte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hpte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/hpte_ctrl.sv */
// ----------------------------------------------------------------------------
// hpte_ctrl
// Command sequencer: clearing pass, primary and secondary group passes,
// write-back and response hand-off.
// ----------------------------------------------------------------------------
module hpte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  hpte_pkg::ctrl_sts_t sts,
  output hpte_pkg::ctrl_cmd_t cmd,
  output logic                req_stall
);
  import hpte_pkg::*;

  hpte_state_e state, state_next;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Ready for a new transaction when idle, or while handing off the last result.
  assign take = (state == ST_IDLE) || (state == ST_RESPOND && !sts.out_busy);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_EVAL_PRI;
      end
      ST_EVAL_PRI: begin
        if (sts.found) begin
          state_next = sts.needs_write ? ST_WRITE_BACK : ST_RESPOND;
        end else begin
          state_next = ST_EVAL_SEC;
        end
      end
      ST_EVAL_SEC: begin
        state_next = sts.needs_write ? ST_WRITE_BACK : ST_RESPOND;
      end
      ST_WRITE_BACK: begin
        state_next = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (!sts.out_busy) state_next = req_valid ? ST_EVAL_PRI : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    req_stall     = !take;
    cmd.load_item = take && req_valid;
    unique case (state)
      ST_CLEAR:      cmd.clear_wr = 1'b1;
      ST_IDLE:       ;
      ST_EVAL_PRI: begin
        cmd.eval     = 1'b1;
        cmd.read_sec = !sts.found;
      end
      ST_EVAL_SEC: begin
        cmd.eval     = 1'b1;
        cmd.eval_sec = 1'b1;
      end
      ST_WRITE_BACK: cmd.wr_row = 1'b1;
      ST_RESPOND:    cmd.out_load = !sts.out_busy;
      default:       ;
    endcase
  end

endmodule

/* rtl/core/hpte_datapath.sv */
// ----------------------------------------------------------------------------
// hpte_datapath
// Hashing, group memory, way match and update, result and output registers.
// ----------------------------------------------------------------------------
module hpte_datapath #(
  parameter int GROUP_COUNT = hpte_pkg::GROUP_COUNT_DEF,
  parameter int WAYS        = hpte_pkg::WAYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hpte_pkg::req_t                      req,
  input  logic                                cfg_we,
  input  logic [hpte_pkg::SIZE_MASK_W-1:0]    cfg_data,
  input  hpte_pkg::ctrl_cmd_t                 cmd,
  output hpte_pkg::ctrl_sts_t                 sts,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output hpte_pkg::rsp_t                      rsp
);
  import hpte_pkg::*;

  localparam int GROUP_W = $clog2(GROUP_COUNT);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int ROW_W   = WAYS * ENTRY_W;

  logic [SIZE_MASK_W-1:0] size_mask;
  req_t                   item;
  hpte_cmd_e              item_cmd;
  logic [HASH_W-1:0]      hash_in, hash_cur;
  logic [GROUP_W-1:0]     grp_in, grp_pri, grp_sec;
  logic [HASH_W-1:0]      m_in, m_pri, m_sec;

  logic                   rd_en, wr_en;
  logic [GROUP_W-1:0]     rd_addr, wr_addr;
  logic [ROW_W-1:0]       rd_data, wr_data;

  entry_t [WAYS-1:0]      row_rd, row_new, row;
  entry_t                 upd;
  logic                   hit;
  logic [WAY_W-1:0]       hit_way;
  logic [GROUP_W-1:0]     wr_grp;
  logic [GROUP_W-1:0]     clear_cnt;

  hpte_status_e           res_status;
  logic [31:0]            res_phys;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_mask <= '0;
    end else if (cfg_we) begin
      size_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= req;
  end

  assign item_cmd = hpte_cmd_e'(item.cmd);

  // Group index: masked hash, then keep the bits the built table holds.
  assign hash_in  = hpte_hash(req.virt_addr);
  assign hash_cur = hpte_hash(item.virt_addr);
  assign m_in     = hpte_masked(hash_in, size_mask);
  assign m_pri    = hpte_masked(hash_cur, size_mask);
  assign m_sec    = hpte_masked(~hash_cur, size_mask);
  assign grp_in   = m_in[GROUP_W-1:0];
  assign grp_pri  = m_pri[GROUP_W-1:0];
  assign grp_sec  = m_sec[GROUP_W-1:0];

  assign rd_en   = cmd.load_item | cmd.read_sec;
  assign rd_addr = cmd.read_sec ? grp_sec : grp_in;
  assign wr_en   = cmd.wr_row | cmd.clear_wr;
  assign wr_addr = cmd.clear_wr ? clear_cnt : wr_grp;
  assign wr_data = cmd.clear_wr ? '0 : ROW_W'(row);

  hpte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GROUP_COUNT)
  ) u_group_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign row_rd = rd_data;

  // First free way for map, first exact tag match otherwise; lowest way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (item_cmd == CMD_MAP) begin
        if (!row_rd[w].valid) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (row_rd[w].valid && row_rd[w].seg == item.virt_addr[31:28] &&
                   row_rd[w].sec == cmd.eval_sec &&
                   row_rd[w].pidx == item.virt_addr[27:22]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    upd = row_rd[hit_way];
    unique case (item_cmd)
      CMD_MAP: begin
        upd.valid = 1'b1;
        upd.seg   = item.virt_addr[31:28];
        upd.sec   = cmd.eval_sec;
        upd.pidx  = item.virt_addr[27:22];
        upd.rpn   = item.phys_addr[31:12];
        upd.prot  = item.prot_bits;
      end
      CMD_TRANSLATE: ;
      CMD_SET_PROT:  upd.prot = item.prot_bits;
      CMD_UNMAP: begin
        // Drop the tag, keep the page word.
        upd.valid = 1'b0;
        upd.seg   = '0;
        upd.sec   = 1'b0;
        upd.pidx  = '0;
      end
      default: ;
    endcase
    row_new          = row_rd;
    row_new[hit_way] = upd;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      row    <= row_new;
      wr_grp <= cmd.eval_sec ? grp_sec : grp_pri;
      if (hit) begin
        res_status <= STATUS_OK;
      end else begin
        res_status <= (item_cmd == CMD_MAP) ? STATUS_FULL : STATUS_NOT_FOUND;
      end
      if (hit && item_cmd == CMD_TRANSLATE) begin
        res_phys <= {row_rd[hit_way].rpn, item.virt_addr[11:0]};
      end else begin
        res_phys <= '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= res_status;
      rsp.phys_result <= res_phys;
    end
  end

  assign sts.found       = hit;
  assign sts.needs_write = hit && (item_cmd != CMD_TRANSLATE);
  assign sts.clear_last  = (clear_cnt == GROUP_W'(GROUP_COUNT - 1));
  assign sts.out_busy    = rsp_valid && rsp_stall;

endmodule

/* rtl/core/hashed_page_table_engine.sv */
// ----------------------------------------------------------------------------
// hashed_page_table_engine
// Hashed page table of WAYS-entry groups: map, translate, set protection
// and unmap, with a primary and a secondary hash group per address.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_t: cmd, virt_addr, phys_addr, prot_bits
//  rsp      out        rsp_valid/rsp_stall  rsp_t: status, phys_result
//  cfg      in         cfg_valid/cfg_ready  size_mask (9 bits), always ready
//
//  After reset a clearing pass writes every group row before the first
//  transaction is taken; configuration writes go on meanwhile.
//  A transaction reads one group per pass through the single read port with
//  registered read, makes a second pass only on a primary miss, and writes the
//  row back for map, set protection and unmap hits.
//  A finished result waits in the output register; the next transaction is
//  taken while it is handed off, and the sequencer holds if the result is stalled.
//  GROUP_COUNT must be a power of two; the block does not enforce this.
// ----------------------------------------------------------------------------
module hashed_page_table_engine #(
  parameter int GROUP_COUNT = hpte_pkg::GROUP_COUNT_DEF,
  parameter int WAYS        = hpte_pkg::WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  hpte_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output hpte_pkg::rsp_t                   rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpte_pkg::SIZE_MASK_W-1:0] cfg_data
);
  import hpte_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  hpte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (ctl),
    .req_stall (req_stall)
  );

  hpte_datapath #(
    .GROUP_COUNT (GROUP_COUNT),
    .WAYS        (WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> rsp_valid)
    else $error("result load did not raise rsp_valid");

  a_wb_after_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_row |-> $past(ctl.eval) && $past(sts.needs_write))
    else $error("write-back without a preceding hit");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_wr |-> req_stall && !ctl.load_item)
    else $error("transaction taken during clearing pass");

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_row || ctl.clear_wr) |-> !(ctl.load_item || ctl.read_sec || ctl.eval))
    else $error("group memory write overlaps a lookup");

endmodule

/* test/hashed_page_table_engine_test.sv */
// ----------------------------------------------------------------------------
// hashed_page_table_engine_test
// Self-checking bench for the hashed page table engine. A shadow copy of the
// page table predicts the responses not fixed in advance. A fixed list of
// commands covers the empty table, a full group pair, secondary hits, unmap
// and remap. Random traffic follows under several size_mask settings, aimed
// at a few crowded groups. Both channels idle at random, and the response
// side holds off once for long enough to back the engine up.
// ----------------------------------------------------------------------------
module hashed_page_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hpte_pkg::*;

  localparam int GROUPS           = GROUP_COUNT_DEF;
  localparam int WAYS             = WAYS_DEF;
  localparam int RANDOM_PER_PHASE = 260;
  localparam int QUIET_LIMIT      = 6000;
  localparam logic [3:0][9:0] HOT_GROUPS = {10'h2aa, 10'h155, 10'h3ff, 10'h000};

  typedef struct packed {
    logic        valid;
    logic [3:0]  seg;
    logic        sec;
    logic [5:0]  pidx;
    logic [19:0] rpn;
    logic [11:0] prot;
  } shadow_pte_t;

  typedef struct packed {
    req_t req;
    logic fixed_exp;
    rsp_t rsp;
  } plan_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req       = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SIZE_MASK_W-1:0] cfg_data  = '0;

  shadow_pte_t            shadow_pt [GROUPS*WAYS];
  logic [SIZE_MASK_W-1:0] size_mask_q;
  rsp_t                   awaited_rsp [$];
  plan_row_t              plan [$];
  logic [31:0]            known_va [$];
  int unsigned            send_calm;
  int unsigned            rsp_seen;
  int unsigned            mismatch_count;
  int unsigned            quiet_cycles;

  hashed_page_table_engine #(
    .GROUP_COUNT (GROUPS),
    .WAYS        (WAYS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow table and return the response it owes.
  function automatic rsp_t table_apply(input req_t r);
    logic [18:0] h;
    logic [18:0] hash;
    int          base;
    int          slot;
    int          pass;
    int          w;
    logic        hit;
    logic        hit_sec;
    shadow_pte_t e;
    rsp_t        o;
    h = {3'b000, r.virt_addr[27:12] ^ {12'd0, r.virt_addr[31:28]}};
    o.status = STATUS_OK;
    o.phys_result = '1;
    hit = 1'b0;
    hit_sec = 1'b0;
    slot = 0;
    for (pass = 0; pass < 2 && !hit; pass++) begin
      hash = (pass == 1) ? ~h : h;
      base = int'((hash & {size_mask_q, 10'h3ff}) % GROUPS) * WAYS;
      for (w = 0; w < WAYS && !hit; w++) begin
        e = shadow_pt[base + w];
        if (r.cmd == CMD_MAP) begin
          hit = !e.valid;
        end else begin
          hit = e.valid && e.seg == r.virt_addr[31:28] && e.pidx == r.virt_addr[27:22] &&
                e.sec == (pass == 1);
        end
        if (hit) begin
          slot = base + w;
          hit_sec = (pass == 1);
        end
      end
    end
    if (!hit) begin
      o.status = (r.cmd == CMD_MAP) ? STATUS_FULL : STATUS_NOT_FOUND;
    end else begin
      case (hpte_cmd_e'(r.cmd))
        CMD_MAP: begin
          shadow_pt[slot] = '{valid: 1'b1, seg: r.virt_addr[31:28], sec: hit_sec,
                              pidx: r.virt_addr[27:22], rpn: r.phys_addr[31:12],
                              prot: r.prot_bits};
        end
        CMD_TRANSLATE: o.phys_result = {shadow_pt[slot].rpn, r.virt_addr[11:0]};
        CMD_SET_PROT:  shadow_pt[slot].prot = r.prot_bits;
        default: begin
          // unmap clears the tag only; the page word stays
          shadow_pt[slot].valid = 1'b0;
          shadow_pt[slot].seg   = '0;
          shadow_pt[slot].sec   = 1'b0;
          shadow_pt[slot].pidx  = '0;
        end
      endcase
    end
    return o;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(input hpte_cmd_e c, input logic [31:0] va,
                                  input logic [31:0] pa, input logic [11:0] prot,
                                  input logic fixed_exp, input hpte_status_e st);
    plan_row_t row;
    row.req = '{cmd: c, virt_addr: va, phys_addr: pa, prot_bits: prot};
    row.fixed_exp = fixed_exp;
    row.rsp = '{status: st, phys_result: 32'hffff_ffff};
    plan.push_back(row);
  endfunction

  // Lookups mostly reuse recently mapped pages; new addresses crowd a few groups.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    logic [3:0]  seg;
    logic [9:0]  grp;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.cmd = CMD_MAP;
    else if (pick < 65) r.cmd = CMD_TRANSLATE;
    else if (pick < 80) r.cmd = CMD_SET_PROT;
    else r.cmd = CMD_UNMAP;
    r.phys_addr = $urandom;
    r.prot_bits = 12'($urandom);
    if (r.cmd != CMD_MAP && known_va.size() != 0 && $urandom_range(0, 3) != 0) begin
      r.virt_addr = {known_va[$urandom_range(0, known_va.size() - 1)][31:12], 12'($urandom)};
    end else if ($urandom_range(0, 1) == 1) begin
      seg = 4'($urandom);
      grp = HOT_GROUPS[$urandom_range(0, 3)];
      r.virt_addr = {seg, 6'($urandom), grp ^ {6'd0, seg}, 12'($urandom)};
    end else begin
      r.virt_addr = $urandom;
    end
    if (r.cmd == CMD_MAP) begin
      known_va.push_back(r.virt_addr);
      if (known_va.size() > 64) void'(known_va.pop_front());
    end
    return r;
  endfunction

  task automatic issue_req(input req_t r, input logic fixed_exp, input rsp_t fixed_rsp);
    rsp_t        predicted;
    int unsigned gap;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = table_apply(r);
    awaited_rsp.push_back(fixed_exp ? fixed_rsp : predicted);
    if (send_calm != 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 49) == 0) begin
      send_calm = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = pause_len();
    end
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_size_mask(input logic [SIZE_MASK_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_mask_q = v;
  endtask

  initial begin : stimulus
    logic [SIZE_MASK_W-1:0] phase_mask [4];
    int                     p;
    int                     k;
    phase_mask[0] = 9'h1ff;
    phase_mask[1] = 9'h000;
    phase_mask[2] = 9'($urandom);
    phase_mask[3] = 9'h155;
    for (k = 0; k < GROUPS*WAYS; k++) shadow_pt[k] = '0;
    size_mask_q = '0;
    send_calm = 0;

    // empty table
    add_row(CMD_TRANSLATE, 32'hffff_ffff, 32'h0000_0000, 12'h000, 1'b1, STATUS_NOT_FOUND);
    add_row(CMD_UNMAP,     32'h0000_0000, 32'hffff_ffff, 12'hfff, 1'b1, STATUS_NOT_FOUND);
    add_row(CMD_SET_PROT,  32'h7fff_f000, 32'h0000_0000, 12'hfff, 1'b1, STATUS_NOT_FOUND);
    // sixteen pages sharing one group pair: primary group first, then secondary
    add_row(CMD_MAP, 32'hf000_0000, 32'hffff_ffff, 12'hfff, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf040_0fff, 32'h0000_0000, 12'h000, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf080_0000, 32'h8000_0fff, 12'h800, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf0c0_0000, 32'h0001_f000, 12'h001, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf100_0000, 32'h1234_5000, 12'h123, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf140_0000, 32'hffff_f000, 12'h7ff, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf180_0000, 32'h0000_1000, 12'h456, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf1c0_0000, 32'hdead_0000, 12'h789, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf200_0000, 32'ha5a5_a000, 12'ha5a, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf240_0000, 32'h5a5a_5000, 12'h5a5, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf280_0000, 32'h00f0_0000, 12'h0f0, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf2c0_0000, 32'h0f00_0000, 12'hf00, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf300_0000, 32'hcafe_0000, 12'h00f, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf340_0000, 32'h7fff_f000, 12'h3c3, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf380_0000, 32'h8000_0000, 12'hc3c, 1'b1, STATUS_OK);
    add_row(CMD_MAP, 32'hf3c0_0000, 32'h1357_9000, 12'h246, 1'b1, STATUS_OK);
    // both groups full
    add_row(CMD_MAP, 32'hffc0_0000, 32'hffff_ffff, 12'hfff, 1'b1, STATUS_FULL);
    add_row(CMD_TRANSLATE, 32'hf300_0fff, 32'h0000_0000, 12'h000, 1'b0, STATUS_OK);
    add_row(CMD_SET_PROT,  32'hf0c0_0000, 32'h0000_0000, 12'hfff, 1'b0, STATUS_OK);
    add_row(CMD_UNMAP,     32'hf0c0_0abc, 32'h0000_0000, 12'h000, 1'b0, STATUS_OK);
    // remap an existing page into the freed way, ahead of the original
    add_row(CMD_MAP,       32'hf140_0000, 32'h0000_0000, 12'h000, 1'b1, STATUS_OK);
    add_row(CMD_TRANSLATE, 32'hf140_0fff, 32'hffff_ffff, 12'hfff, 1'b0, STATUS_OK);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) issue_req(plan[i].req, plan[i].fixed_exp, plan[i].rsp);
    req_valid <= 1'b0;

    for (p = 0; p < 4; p++) begin
      while (awaited_rsp.size() != 0) @(posedge clk);
      write_size_mask(phase_mask[p]);
      repeat (RANDOM_PER_PHASE) issue_req(random_req(), 1'b0, '0);
      req_valid <= 1'b0;
    end

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Response side: random stalls, quiet stretches and one long hold-off.
  initial begin : rsp_side
    int unsigned stall_left;
    int unsigned calm_left;
    logic        held_off;
    stall_left = 0;
    calm_left = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (!held_off && rsp_seen >= 150) begin
        held_off = 1'b1;
        stall_left = 250;
      end else if (calm_left != 0) begin
        calm_left--;
      end else if ($urandom_range(0, 59) == 0) begin
        calm_left = $urandom_range(30, 100);
      end else begin
        stall_left = pause_len();
      end
      rsp_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response, status %0d phys %h", $time, rsp.status,
                 rsp.phys_result);
        mismatch_count++;
      end else begin
        exp_rsp = awaited_rsp.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, exp_rsp.status,
                   rsp.status);
          mismatch_count++;
        end
        if (rsp.phys_result !== exp_rsp.phys_result) begin
          $display("%0t: phys_result mismatch, expected %h, got %h", $time,
                   exp_rsp.phys_result, rsp.phys_result);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding", $time,
               QUIET_LIMIT, awaited_rsp.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
